// ===== design/srbo_pkg.sv =====
// Shared types and constants for the sample ring buffer with overwrite.
package srbo_pkg;

	// Fixed widths of the beat fields
	localparam int unsigned SMP_W = 16;
	localparam int unsigned CNT_W = 7;
	localparam int unsigned CMD_W = 2;

	// Depth of the command queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QIDX_W = 1;
	localparam int unsigned QCNT_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_DRAIN = 2'd3
	} cmd_e_t;

	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_BURST = 1'b1
	} back_state_t;

	typedef struct packed {
		logic [CMD_W-1:0]        command;
		logic signed [SMP_W-1:0] sample_in;
		logic [CNT_W-1:0]        read_count;
	} item_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample_out;
		logic                    sample_valid;
		logic                    last;
		logic [CNT_W-1:0]        delivered;
		logic                    overwrote;
		logic [CNT_W-1:0]        fill_level;
	} result_t;

	// Classified command as it waits in the queue
	typedef struct packed {
		cmd_e_t                  cmd;
		logic signed [SMP_W-1:0] sample;
		logic [CNT_W-1:0]        count;
	} q_entry_t;

	// Head of the queue as the back sees it
	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_head_t;

	// Result fields other than the sample, carried through the output stage
	typedef struct packed {
		logic             sample_valid;
		logic             last;
		logic [CNT_W-1:0] delivered;
		logic             overwrote;
		logic [CNT_W-1:0] fill_level;
	} res_meta_t;

endpackage

// ===== design/sample_ring_buffer_overwrite_unit.sv =====
// Top level of the sample ring buffer that overwrites the oldest sample when full.
//
// Command channel: drive item and raise start; the beat is taken at a rising edge
// where start is high and busy is low. Commands are write, read burst, clear and
// drain. A two-entry queue decouples command intake from execution.
// Result channel: result_valid marks each result beat for exactly one cycle and the
// receiver must take it then; there is no way to hold results off.
// Path: a taken beat waits in the queue until the back end pops it, and each result
// is registered in the output stage; burst samples pass the storage read register.
// Throughput: write and clear run straight from the idle state, so a stream of
// writes runs at one per cycle. A read or drain returning n samples sets up in the
// idle state, then gives one sample per cycle from the storage read port in the burst
// state; an empty read or drain ends in idle. busy rises while the queue is full.
// Every result carries the fill level that holds after its whole command.
// Reset: arst_n clears the pointers, fill count, queue and output strobe at once;
// sample storage is not cleared and is never read before being written.
module sample_ring_buffer_overwrite_unit #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  srbo_pkg::item_t    item,
	output logic               result_valid,
	output srbo_pkg::result_t  result
);

	srbo_pkg::q_head_t head;
	logic              pop;

	srbo_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.pop    (pop),
		.head   (head)
	);

	srbo_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result       (result)
	);

	// Fill level never exceeds the capacity
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.fill_level <= srbo_pkg::CNT_W'(CAPACITY)))
		else $error("fill level above capacity");

	// An overwrite only happens on a full buffer
	a_ovw_full: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.overwrote) |->
			(result.fill_level == srbo_pkg::CNT_W'(CAPACITY) && !result.sample_valid))
		else $error("overwrite reported on a buffer that is not full");

	// A delivered count only appears on the last beat of a command
	a_delivered_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.delivered != '0) |-> (result.last && result.sample_valid))
		else $error("delivered count on a non-final beat");

	// Beats without a stored sample carry a zero sample and are the last beat
	a_zero_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.sample_valid) |-> (result.sample_out == '0 && result.last))
		else $error("invalid sample beat is not zero or not final");

endmodule

// ===== design/srbo_front.sv =====
// Front end: accepts command beats, classifies them and queues them for the back end.
module srbo_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  srbo_pkg::item_t    item,
	input  logic               pop,
	output srbo_pkg::q_head_t  head
);

	srbo_pkg::q_entry_t              entry_q [srbo_pkg::QUEUE_DEPTH];
	logic [srbo_pkg::QIDX_W-1:0]     wr_idx_q;
	logic [srbo_pkg::QIDX_W-1:0]     rd_idx_q;
	logic [srbo_pkg::QCNT_W-1:0]     count_q;
	srbo_pkg::q_entry_t              new_entry;
	logic                            push;
	logic                            do_pop;

	// Classify the incoming beat
	always_comb begin
		new_entry.cmd    = srbo_pkg::cmd_e_t'(item.command);
		new_entry.sample = item.sample_in;
		new_entry.count  = item.read_count;
	end

	assign busy   = (count_q == srbo_pkg::QCNT_W'(srbo_pkg::QUEUE_DEPTH));
	assign push   = start && !busy;
	assign do_pop = pop && (count_q != '0);

	// Store the queued payload
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_idx_q] <= new_entry;
		end
	end

	// Advance the queue pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_idx_q <= wr_idx_q + srbo_pkg::QIDX_W'(1);
			end
			if (do_pop) begin
				rd_idx_q <= rd_idx_q + srbo_pkg::QIDX_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + srbo_pkg::QCNT_W'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - srbo_pkg::QCNT_W'(1);
			end
		end
	end

	assign head.valid = (count_q != '0);
	assign head.entry = entry_q[rd_idx_q];

endmodule

// ===== design/srbo_back.sv =====
// Back end: ring storage, pointers and execution of queued commands.
module srbo_back #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  srbo_pkg::q_head_t  head,
	output logic               pop,
	output logic               result_valid,
	output srbo_pkg::result_t  result
);

	localparam int unsigned PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW    = srbo_pkg::CNT_W;

	// Sample storage
	logic signed [srbo_pkg::SMP_W-1:0] mem [CAPACITY];
	logic signed [srbo_pkg::SMP_W-1:0] rd_data_q;

	// Control state
	srbo_pkg::back_state_t state_q, state_d;
	logic [PTR_W-1:0]      rp_q, rp_d, wp_q, wp_d;
	logic [PTR_W-1:0]      rp_nx, wp_nx;
	logic [CW-1:0]         cnt_q, cnt_d;
	logic [CW-1:0]         remain_q, remain_d;
	logic [CW-1:0]         total_q, total_d;
	logic [CW-1:0]         fill_after_q, fill_after_d;
	logic                  drain_q, drain_d;

	// Output stage
	logic                  res_v_s1;
	srbo_pkg::res_meta_t   meta_s1;

	// Combinational controls
	logic                  mem_we;
	logic                  rd_en;
	logic                  emit;
	srbo_pkg::res_meta_t   meta;
	logic [CW-1:0]         n_take;
	logic [CW-1:0]         fill_left;
	logic                  burst_last;

	assign rp_nx = (rp_q == PTR_W'(CAPACITY - 1)) ? '0 : rp_q + PTR_W'(1);
	assign wp_nx = (wp_q == PTR_W'(CAPACITY - 1)) ? '0 : wp_q + PTR_W'(1);

	// Work out how many samples a read or drain returns
	always_comb begin
		if (head.entry.cmd == srbo_pkg::CMD_READ) begin
			n_take    = (head.entry.count < cnt_q) ? head.entry.count : cnt_q;
			fill_left = cnt_q - n_take;
		end else begin
			n_take    = cnt_q;
			fill_left = '0;
		end
	end

	assign burst_last = (remain_q == CW'(1));

	// Next state and controls
	always_comb begin
		state_d      = state_q;
		rp_d         = rp_q;
		wp_d         = wp_q;
		cnt_d        = cnt_q;
		remain_d     = remain_q;
		total_d      = total_q;
		fill_after_d = fill_after_q;
		drain_d      = drain_q;
		mem_we       = 1'b0;
		rd_en        = 1'b0;
		emit         = 1'b0;
		pop          = 1'b0;
		meta         = '0;
		meta.last    = 1'b1;
		case (state_q)
			srbo_pkg::ST_IDLE: begin
				if (head.valid) begin
					pop  = 1'b1;
					case (head.entry.cmd)
						srbo_pkg::CMD_WRITE: begin
							mem_we = 1'b1;
							wp_d   = wp_nx;
							emit   = 1'b1;
							if (cnt_q < CW'(CAPACITY)) begin
								cnt_d = cnt_q + CW'(1);
							end else begin
								rp_d           = rp_nx;
								meta.overwrote = 1'b1;
							end
							meta.fill_level = cnt_d;
						end
						srbo_pkg::CMD_CLEAR: begin
							rp_d  = '0;
							wp_d  = '0;
							cnt_d = '0;
							emit  = 1'b1;
						end
						srbo_pkg::CMD_READ, srbo_pkg::CMD_DRAIN: begin
							if (n_take == '0) begin
								emit            = 1'b1;
								meta.fill_level = fill_left;
								if (head.entry.cmd == srbo_pkg::CMD_DRAIN) begin
									rp_d  = '0;
									wp_d  = '0;
									cnt_d = '0;
								end
							end else begin
								state_d      = srbo_pkg::ST_BURST;
								remain_d     = n_take;
								total_d      = n_take;
								fill_after_d = fill_left;
								drain_d      = (head.entry.cmd == srbo_pkg::CMD_DRAIN);
							end
						end
						default: begin
							emit = 1'b0;
						end
					endcase
				end
			end
			srbo_pkg::ST_BURST: begin
				rd_en             = 1'b1;
				emit              = 1'b1;
				rp_d              = rp_nx;
				remain_d          = remain_q - CW'(1);
				meta.sample_valid = 1'b1;
				meta.last         = burst_last;
				meta.delivered    = burst_last ? total_q : '0;
				meta.fill_level   = fill_after_q;
				if (burst_last) begin
					state_d = srbo_pkg::ST_IDLE;
					cnt_d   = fill_after_q;
					if (drain_q) begin
						rp_d = '0;
						wp_d = '0;
					end
				end
			end
			default: begin
				state_d = srbo_pkg::ST_IDLE;
			end
		endcase
	end

	// Write and read the sample storage
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wp_q] <= head.entry.sample;
		end
		if (rd_en) begin
			rd_data_q <= mem[rp_q];
		end
	end

	// Hold the result fields beside the read data
	always_ff @(posedge clk) begin
		meta_s1 <= meta;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= srbo_pkg::ST_IDLE;
			rp_q         <= '0;
			wp_q         <= '0;
			cnt_q        <= '0;
			remain_q     <= '0;
			total_q      <= '0;
			fill_after_q <= '0;
			drain_q      <= 1'b0;
			res_v_s1     <= 1'b0;
		end else begin
			state_q      <= state_d;
			rp_q         <= rp_d;
			wp_q         <= wp_d;
			cnt_q        <= cnt_d;
			remain_q     <= remain_d;
			total_q      <= total_d;
			fill_after_q <= fill_after_d;
			drain_q      <= drain_d;
			res_v_s1     <= emit;
		end
	end

	// Drive the result beat
	assign result_valid        = res_v_s1;
	assign result.sample_out   = meta_s1.sample_valid ? rd_data_q : '0;
	assign result.sample_valid = meta_s1.sample_valid;
	assign result.last         = meta_s1.last;
	assign result.delivered    = meta_s1.delivered;
	assign result.overwrote    = meta_s1.overwrote;
	assign result.fill_level   = meta_s1.fill_level;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the sample ring buffer with overwrite of the oldest sample.
`timescale 1ns / 100ps

module tb_top;

	localparam int CAP = 64;
	localparam int CYCLE_LIMIT = 200000;

	// Mirror of the ring buffer: predicts every result beat and checks it on arrival
	class ring_mirror;
		logic signed [srbo_pkg::SMP_W-1:0] samples [CAP];
		int rd_pos;
		int wr_pos;
		int count;
		srbo_pkg::result_t pending[$];
		int errors;
		int commands;
		int results_seen;
		int overwrites;
		int longest_burst;

		function new();
			foreach (samples[i]) samples[i] = '0;
			rd_pos = 0;
			wr_pos = 0;
			count = 0;
			errors = 0;
			commands = 0;
			results_seen = 0;
			overwrites = 0;
			longest_burst = 0;
		endfunction

		function int step_pos(int p);
			return (p + 1) % CAP;
		endfunction

		// Append one expected beat at the tail
		function void queue_beat(srbo_pkg::result_t r);
			pending.insert(pending.size(), r);
		endfunction

		// Work out the results of one accepted command and advance the mirror
		function void absorb_command(srbo_pkg::item_t it);
			srbo_pkg::result_t r;
			int n;
			int fill_after;
			srbo_pkg::cmd_e_t c;
			r = '0;
			c = srbo_pkg::cmd_e_t'(it.command);
			commands++;
			case (c)
				srbo_pkg::CMD_WRITE: begin
					samples[wr_pos] = it.sample_in;
					wr_pos = step_pos(wr_pos);
					if (count < CAP) begin
						count++;
					end else begin
						rd_pos = step_pos(rd_pos);
						r.overwrote = 1'b1;
						overwrites++;
					end
					r.last = 1'b1;
					r.fill_level = srbo_pkg::CNT_W'(count);
					queue_beat(r);
				end
				srbo_pkg::CMD_CLEAR: begin
					rd_pos = 0;
					wr_pos = 0;
					count = 0;
					r.last = 1'b1;
					queue_beat(r);
				end
				default: begin
					// read burst is limited to the fill level; drain takes everything
					if (c == srbo_pkg::CMD_READ)
						n = (int'(it.read_count) < count) ? int'(it.read_count) : count;
					else
						n = count;
					fill_after = count - n;
					if (n > longest_burst)
						longest_burst = n;
					r.fill_level = srbo_pkg::CNT_W'(fill_after);
					if (n == 0) begin
						r.last = 1'b1;
						queue_beat(r);
					end
					for (int i = 0; i < n; i++) begin
						r.sample_out = samples[rd_pos];
						r.sample_valid = 1'b1;
						r.last = (i == n - 1);
						r.delivered = (i == n - 1) ? srbo_pkg::CNT_W'(n) : '0;
						queue_beat(r);
						rd_pos = step_pos(rd_pos);
					end
					if (c == srbo_pkg::CMD_READ) begin
						count = fill_after;
					end else begin
						rd_pos = 0;
						wr_pos = 0;
						count = 0;
					end
				end
			endcase
		endfunction

		function void report(string why, srbo_pkg::result_t want, srbo_pkg::result_t got);
			errors++;
			if (errors <= 10) begin
				$display("[%0t] %s: exp smp=%0d vld=%b last=%b dlv=%0d ovw=%b fill=%0d",
					$time, why, want.sample_out, want.sample_valid, want.last,
					want.delivered, want.overwrote, want.fill_level);
				$display("        got smp=%0d vld=%b last=%b dlv=%0d ovw=%b fill=%0d",
					got.sample_out, got.sample_valid, got.last, got.delivered,
					got.overwrote, got.fill_level);
			end
		endfunction

		// Compare one result beat with the oldest expectation
		function void compare_result(srbo_pkg::result_t got);
			srbo_pkg::result_t want;
			results_seen++;
			if (pending.size() == 0) begin
				report("result with nothing expected", '0, got);
				return;
			end
			want = pending.pop_front();
			if (got.sample_out !== want.sample_out ||
					got.sample_valid !== want.sample_valid ||
					got.last !== want.last ||
					got.delivered !== want.delivered ||
					got.overwrote !== want.overwrote ||
					got.fill_level !== want.fill_level)
				report("result mismatch", want, got);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	srbo_pkg::item_t item;
	logic result_valid;
	srbo_pkg::result_t result;

	ring_mirror sb = new();
	bit gaps_on;
	int cycles = 0;

	sample_ring_buffer_overwrite_unit #(.CAPACITY(CAP)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Track accepted beats and check result beats
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.absorb_command(item);
			if (result_valid)
				sb.compare_result(result);
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still expected",
				cycles, sb.pending.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic srbo_pkg::item_t make_item(srbo_pkg::cmd_e_t c,
			logic signed [srbo_pkg::SMP_W-1:0] s, logic [srbo_pkg::CNT_W-1:0] n);
		srbo_pkg::item_t it;
		it.command = c;
		it.sample_in = s;
		it.read_count = n;
		return it;
	endfunction

	// Mostly writes and short reads, with the odd clear, drain and oversized read
	function automatic srbo_pkg::item_t random_command();
		int pick;
		logic [srbo_pkg::CNT_W-1:0] n;
		pick = $urandom_range(0, 99);
		n = ($urandom_range(0, 3) == 0) ? srbo_pkg::CNT_W'($urandom_range(0, 127))
			: srbo_pkg::CNT_W'($urandom_range(0, 8));
		if (pick < 55)
			return make_item(srbo_pkg::CMD_WRITE, srbo_pkg::SMP_W'($urandom), n);
		else if (pick < 85)
			return make_item(srbo_pkg::CMD_READ, srbo_pkg::SMP_W'($urandom), n);
		else if (pick < 92)
			return make_item(srbo_pkg::CMD_CLEAR, srbo_pkg::SMP_W'($urandom), n);
		return make_item(srbo_pkg::CMD_DRAIN, srbo_pkg::SMP_W'($urandom), n);
	endfunction

	// Drop start with junk on the item bus, then wait out the hold-off given by n
	task automatic hold_off(int n);
		start <= 1'b0;
		item <= make_item(
			srbo_pkg::cmd_e_t'(srbo_pkg::CMD_W'($urandom_range(0, 3))),
			srbo_pkg::SMP_W'($urandom), srbo_pkg::CNT_W'($urandom));
		repeat (n) @(posedge clk);
	endtask

	// Present one beat and hold it until the block takes it
	task automatic send(srbo_pkg::item_t it);
		if (gaps_on && $urandom_range(0, 3) == 0)
			hold_off($urandom_range(1, 8));
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
	endtask

	// Stop sending until every expected result has come back
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int extra;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		gaps_on = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty buffer: read, drain and zero-count read
		send(make_item(srbo_pkg::CMD_READ, 16'sd0, 7'd5));
		send(make_item(srbo_pkg::CMD_DRAIN, 16'sd0, 7'd0));
		send(make_item(srbo_pkg::CMD_READ, 16'sd0, 7'd0));
		// Extreme and alternating sample values
		send(make_item(srbo_pkg::CMD_WRITE, -16'sd32768, 7'd0));
		send(make_item(srbo_pkg::CMD_WRITE, 16'sd32767, 7'd127));
		send(make_item(srbo_pkg::CMD_WRITE, 16'sd0, 7'd0));
		send(make_item(srbo_pkg::CMD_WRITE, -16'sd1, 7'd0));
		send(make_item(srbo_pkg::CMD_WRITE, 16'sh5555, 7'd0));
		// Zero count with data, partial read, read beyond fill and capacity
		send(make_item(srbo_pkg::CMD_READ, 16'sd0, 7'd0));
		send(make_item(srbo_pkg::CMD_READ, 16'sd0, 7'd2));
		send(make_item(srbo_pkg::CMD_READ, -16'sd1, 7'd127));
		// Clear when empty, clear with data, read after clear
		send(make_item(srbo_pkg::CMD_CLEAR, 16'sd0, 7'd0));
		send(make_item(srbo_pkg::CMD_WRITE, 16'sh2AAA, 7'd0));
		send(make_item(srbo_pkg::CMD_WRITE, 16'sd1, 7'd0));
		send(make_item(srbo_pkg::CMD_CLEAR, 16'sd0, 7'd0));
		send(make_item(srbo_pkg::CMD_READ, 16'sd0, 7'd3));
		// Drain one sample, then a read at exactly capacity
		send(make_item(srbo_pkg::CMD_WRITE, 16'sd1234, 7'd0));
		send(make_item(srbo_pkg::CMD_DRAIN, 16'sd0, 7'd0));
		send(make_item(srbo_pkg::CMD_WRITE, -16'sd4321, 7'd0));
		send(make_item(srbo_pkg::CMD_WRITE, 16'sd77, 7'd0));
		send(make_item(srbo_pkg::CMD_READ, 16'sd0, 7'd64));
		settle();

		// Random mix with gaps
		repeat (40)
			send(random_command());
		settle();

		// Fill to capacity, run over it, then read everything back
		extra = $urandom_range(1, 8);
		repeat (CAP - sb.count + extra)
			send(make_item(srbo_pkg::CMD_WRITE, srbo_pkg::SMP_W'($urandom),
				srbo_pkg::CNT_W'($urandom)));
		send(make_item(srbo_pkg::CMD_READ, srbo_pkg::SMP_W'($urandom),
			srbo_pkg::CNT_W'($urandom_range(64, 127))));

		// Back-to-back tail with no gaps, ending in a drain
		gaps_on = 1'b0;
		repeat (30)
			send(random_command());
		send(make_item(srbo_pkg::CMD_DRAIN, 16'sd0, 7'd0));
		settle();
		repeat (8) @(posedge clk);

		if (sb.pending.size() != 0) begin
			$display("%0d expected results never arrived", sb.pending.size());
			sb.errors++;
		end
		$display("Covered %0d commands and %0d result beats, %0d overwrites when full,",
			sb.commands, sb.results_seen, sb.overwrites);
		$display("longest burst %0d samples, %0d mismatches", sb.longest_burst,
			sb.errors);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== files.f =====
design/srbo_pkg.sv
design/srbo_front.sv
design/srbo_back.sv
design/sample_ring_buffer_overwrite_unit.sv
verif/tb_top.sv
